// ===== design/sap_pkg.sv =====
// shared types, constants and the square root step for the shape area/perimeter unit
// no dependencies; used by every module of the block
`default_nettype none

package sap_pkg;

    localparam int DIM_BITS    = 24;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * DIM_BITS;
    localparam int D2_BITS     = 2 * COORD_BITS + 1;
    localparam int AREA_BITS   = 42;
    localparam int PERIM_BITS  = 27;
    localparam int PI_BITS     = 26;
    localparam int ROOT_BITS   = COORD_BITS + 1 + FRAC_BITS;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int SQRT_STAGES = 5;
    localparam int SQRT_STEPS  = ROOT_BITS / SQRT_STAGES;
    localparam int SIDE_DEPTH  = SQRT_STAGES;
    localparam int PIPE_DEPTH  = 3 + SQRT_STAGES + 1;

    localparam logic [PI_BITS-1:0] PI_Q24 = 26'd52707179;

    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;
    localparam logic [1:0] KIND_TRI    = 2'd3;

    // vertices, ax in the lowest bits
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] ax;
    } vert_t;

    // front end result at the end of stage three
    typedef struct packed {
        logic [1:0]                  kind;
        logic [SQ_BITS-FRAC_BITS-1:0] area_rs;
        logic [41:0]                 cp_hi;
        logic [57:0]                 cp_lo;
        logic [AREA_BITS-1:0]        tri_area;
        logic [PERIM_BITS-1:0]       perim_base;
        logic [D2_BITS-1:0]          d2_a;
        logic [D2_BITS-1:0]          d2_b;
        logic [D2_BITS-1:0]          d2_c;
    } front_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [AREA_BITS-1:0]  area;
        logic [PERIM_BITS-1:0] perim;
    } side_t;

    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [ROOT_BITS-1:0] root;
        logic [REM_BITS-1:0]  rem;
    } sqrt_st_t;

    // one digit of the restoring square root
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        sqrt_st_t            r;
        logic [REM_BITS+1:0] rem4;
        logic [REM_BITS+1:0] trial;
        rem4  = {s.rem, s.rad[RAD_BITS-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[RAD_BITS-3:0], 2'b00};
        if (rem4 >= trial) begin
            r.rem  = REM_BITS'(rem4 - trial);
            r.root = {s.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            r.rem  = REM_BITS'(rem4);
            r.root = {s.root[ROOT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sap_front.sv =====
// stages one to three: input capture, products and squares, partial sums
// depends on sap_pkg
`default_nettype none

module sap_front (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [1:0]                        kind_i,
    input  wire logic [sap_pkg::DIM_BITS-1:0]      dim_a_i,
    input  wire logic [sap_pkg::DIM_BITS-1:0]      dim_b_i,
    input  wire sap_pkg::vert_t                    vert_i,
    output sap_pkg::front_t                        front_o
);
    import sap_pkg::*;

    // stage one registers
    logic [1:0]                  kind1_reg;
    logic [DIM_BITS-1:0]         a1_reg, b1_reg;
    logic signed [DIFF_BITS-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, d3x_reg, d3y_reg;

    // stage two registers
    logic [1:0]                   kind2_reg;
    logic [SQ_BITS-1:0]           sq2_reg;
    logic [PERIM_BITS-1:0]        perim2_reg;
    logic signed [2*DIFF_BITS-1:0] m1_reg, m2_reg;
    logic [31:0]                  s1x_reg, s1y_reg, s2x_reg, s2y_reg, s3x_reg, s3y_reg;

    logic signed [2*DIFF_BITS-1:0] m1_next, m2_next;
    logic signed [2*DIFF_BITS-1:0] q1x, q1y, q2x, q2y, q3x, q3y;
    logic [SQ_BITS-1:0]           sq_next;
    logic [PERIM_BITS-1:0]        perim_next;
    logic [DIM_BITS+PI_BITS-1:0]  circ_p;

    // stage three
    front_t                        f3_reg, f3_next;
    logic signed [2*DIFF_BITS:0]   cross_v;
    logic [2*DIFF_BITS:0]          mag;

    // vertex differences, edges taken as ab, bc, ca
    always_ff @(posedge aclk) begin
        if (en) begin
            kind1_reg <= kind_i;
            a1_reg    <= dim_a_i;
            b1_reg    <= dim_b_i;
            d1x_reg   <= DIFF_BITS'(vert_i.ax) - DIFF_BITS'(vert_i.bx);
            d1y_reg   <= DIFF_BITS'(vert_i.ay) - DIFF_BITS'(vert_i.by_coord);
            d2x_reg   <= DIFF_BITS'(vert_i.bx) - DIFF_BITS'(vert_i.cx);
            d2y_reg   <= DIFF_BITS'(vert_i.by_coord) - DIFF_BITS'(vert_i.cy);
            d3x_reg   <= DIFF_BITS'(vert_i.cx) - DIFF_BITS'(vert_i.ax);
            d3y_reg   <= DIFF_BITS'(vert_i.cy) - DIFF_BITS'(vert_i.ay);
        end
    end

    // products: dimension product, circle perimeter, cross terms, squares
    always_comb begin
        sq_next = SQ_BITS'(a1_reg) * SQ_BITS'((kind1_reg == KIND_RECT) ? b1_reg : a1_reg);
        circ_p  = (DIM_BITS+PI_BITS)'(a1_reg) * (DIM_BITS+PI_BITS)'(PI_Q24);
        case (kind1_reg)
            KIND_RECT:   perim_next = PERIM_BITS'({1'b0, a1_reg} + {1'b0, b1_reg}) << 1;
            KIND_SQUARE: perim_next = PERIM_BITS'(a1_reg) << 2;
            KIND_CIRCLE: perim_next = PERIM_BITS'(circ_p >> 23);
            default:     perim_next = '0;
        endcase
        m1_next = d1y_reg * d3x_reg;
        m2_next = d1x_reg * d3y_reg;
        q1x = d1x_reg * d1x_reg;
        q1y = d1y_reg * d1y_reg;
        q2x = d2x_reg * d2x_reg;
        q2y = d2y_reg * d2y_reg;
        q3x = d3x_reg * d3x_reg;
        q3y = d3y_reg * d3y_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind2_reg  <= kind1_reg;
            sq2_reg    <= sq_next;
            perim2_reg <= perim_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            s1x_reg    <= q1x[31:0];
            s1y_reg    <= q1y[31:0];
            s2x_reg    <= q2x[31:0];
            s2y_reg    <= q2y[31:0];
            s3x_reg    <= q3x[31:0];
            s3y_reg    <= q3y[31:0];
        end
    end

    // squared edge lengths, cross magnitude, circle area partial products
    always_comb begin
        cross_v = (2*DIFF_BITS+1)'(m1_reg) - (2*DIFF_BITS+1)'(m2_reg);
        mag     = cross_v[2*DIFF_BITS] ? (2*DIFF_BITS+1)'(-cross_v)
                                       : (2*DIFF_BITS+1)'(cross_v);
        f3_next.kind       = kind2_reg;
        f3_next.area_rs    = sq2_reg[SQ_BITS-1:FRAC_BITS];
        f3_next.cp_hi      = 42'(sq2_reg[SQ_BITS-1:32]) * 42'(PI_Q24);
        f3_next.cp_lo      = 58'(sq2_reg[31:0]) * 58'(PI_Q24);
        f3_next.tri_area   = AREA_BITS'(mag) << (FRAC_BITS - 1);
        f3_next.perim_base = perim2_reg;
        f3_next.d2_a       = D2_BITS'(s1x_reg) + D2_BITS'(s1y_reg);
        f3_next.d2_b       = D2_BITS'(s2x_reg) + D2_BITS'(s2y_reg);
        f3_next.d2_c       = D2_BITS'(s3x_reg) + D2_BITS'(s3y_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_reg <= f3_next;
        end
    end

    assign front_o = f3_reg;

endmodule

`default_nettype wire

// ===== design/sap_sqrt.sv =====
// pipelined integer square root of a squared edge length scaled by 2^(2*frac)
// depends on sap_pkg
`default_nettype none

module sap_sqrt (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic [sap_pkg::D2_BITS-1:0]    d2_i,
    output logic      [sap_pkg::ROOT_BITS-1:0]  root_o
);
    import sap_pkg::*;

    sqrt_st_t st_reg  [SQRT_STAGES];
    sqrt_st_t st_next [SQRT_STAGES];

    // each stage resolves a fixed group of root digits
    always_comb begin
        sqrt_st_t s;
        for (int g = 0; g < SQRT_STAGES; g++) begin
            if (g == 0) begin
                s.rad  = {{(RAD_BITS-D2_BITS-2*FRAC_BITS){1'b0}}, d2_i, {(2*FRAC_BITS){1'b0}}};
                s.root = '0;
                s.rem  = '0;
            end else begin
                s = st_reg[g-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                s = sqrt_step(s);
            end
            st_next[g] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < SQRT_STAGES; g++) begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign root_o = st_reg[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ===== design/shape_area_perimeter.sv =====
// Geometry unit: one shape per transfer in, its area and perimeter (unsigned, 8 fraction
// bits, truncated) out. Fully pipelined, one item accepted per cycle while the output is
// not stalled; the depth is set by three stages of multipliers and adders followed by the
// five-stage square root used for the triangle edges and the output register. The whole
// pipe advances together and holds while a finished result waits on m_axis_tready.
// depends on sap_pkg, sap_front, sap_sqrt
`default_nettype none

module shape_area_perimeter (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dim_a, dim_b, ax, ay, bx, by_coord, cx, cy
    input  wire logic [143:0] s_axis_tdata,
    // shape_kind
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // area, perimeter, zero pad
    output logic [71:0]       m_axis_tdata
);
    import sap_pkg::*;

    logic                   en;
    logic [PIPE_DEPTH-1:0]  vld_reg, vld_next;
    vert_t                  vert;
    front_t                 front;
    logic [ROOT_BITS-1:0]   root_a, root_b, root_c;
    side_t                  side_reg [SIDE_DEPTH];
    side_t                  side_next;
    logic [AREA_BITS-1:0]   area_reg, area_next;
    logic [PERIM_BITS-1:0]  perim_reg, perim_next;

    // global advance: move when the output is empty or being taken
    assign en            = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    assign vld_next      = {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // unpack vertices
    assign vert = s_axis_tdata[143:48];

    sap_front u_front (
        .aclk    (aclk),
        .en      (en),
        .kind_i  (s_axis_tuser),
        .dim_a_i (s_axis_tdata[23:0]),
        .dim_b_i (s_axis_tdata[47:24]),
        .vert_i  (vert),
        .front_o (front)
    );

    sap_sqrt u_sqrt_a (.aclk(aclk), .en(en), .d2_i(front.d2_a), .root_o(root_a));
    sap_sqrt u_sqrt_b (.aclk(aclk), .en(en), .d2_i(front.d2_b), .root_o(root_b));
    sap_sqrt u_sqrt_c (.aclk(aclk), .en(en), .d2_i(front.d2_c), .root_o(root_c));

    // area select, circle partials joined
    always_comb begin
        side_next.kind  = front.kind;
        side_next.perim = front.perim_base;
        case (front.kind)
            KIND_CIRCLE: side_next.area = front.cp_hi + AREA_BITS'(front.cp_lo[57:32]);
            KIND_TRI:    side_next.area = front.tri_area;
            default:     side_next.area = AREA_BITS'(front.area_rs);
        endcase
    end

    // side data delay line matched to the square root
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // output register
    always_comb begin
        area_next = side_reg[SIDE_DEPTH-1].area;
        if (side_reg[SIDE_DEPTH-1].kind == KIND_TRI) begin
            perim_next = PERIM_BITS'(root_a) + PERIM_BITS'(root_b) + PERIM_BITS'(root_c);
        end else begin
            perim_next = side_reg[SIDE_DEPTH-1].perim;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg  <= area_next;
            perim_reg <= perim_next;
        end
    end

    assign m_axis_tdata = {3'b000, perim_reg, area_reg};

    // an accepted transfer enters stage one
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted transfer missing from stage one");

    // the pipe holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // a stalled result keeps its data
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== dv/tb_shape_area_perimeter.sv =====
// testbench for shape_area_perimeter: random and directed shapes, predicted area/perimeter
// depends on sap_pkg and the shape_area_perimeter RTL
`timescale 1ns / 1ps

module tb_shape_area_perimeter;
    import sap_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [41:0] AREA_ALL = '1;
    localparam logic [26:0] PERIM_ALL = '1;

    typedef struct packed {
        logic [41:0] area;
        logic [26:0] perim;
    } shape_res_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [143:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [71:0]   m_axis_tdata;

    shape_res_t    expected_q[$];
    int            errors = 0;
    int            results_seen = 0;
    int            items_sent = 0;
    int            kind_count[4] = '{0, 0, 0, 0};
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_off_cycles = 0;
    int            quiet_cycles = 0;

    always #5 aclk = ~aclk;

    shape_area_perimeter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // integer square root of d2 scaled by 2^16, one bit per iteration
    function automatic logic [63:0] edge_root(input longint dx, input longint dy);
        logic [63:0] rad;
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        rad = (64'(dx * dx) + 64'(dy * dy)) << (2 * FRAC_BITS);
        root = '0;
        rem = '0;
        for (int k = ROOT_BITS - 1; k >= 0; k--) begin
            rem = (rem << 2) | ((rad >> (2 * k)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // area and perimeter of one shape
    function automatic shape_res_t shape_measure(input logic [1:0] kind,
                                                 input logic [143:0] data);
        shape_res_t  r;
        logic [127:0] ar;
        logic [127:0] pr;
        logic [23:0]  da;
        logic [23:0]  db;
        longint       x1, y1, x2, y2, x3, y3, cr;
        da = data[23:0];
        db = data[47:24];
        x1 = longint'($signed(data[63:48]));
        y1 = longint'($signed(data[79:64]));
        x2 = longint'($signed(data[95:80]));
        y2 = longint'($signed(data[111:96]));
        x3 = longint'($signed(data[127:112]));
        y3 = longint'($signed(data[143:128]));
        case (kind)
            KIND_RECT: begin
                ar = (128'(da) * 128'(db)) >> FRAC_BITS;
                pr = 128'(2) * (128'(da) + 128'(db));
            end
            KIND_SQUARE: begin
                ar = (128'(da) * 128'(da)) >> FRAC_BITS;
                pr = 128'(4) * 128'(da);
            end
            KIND_CIRCLE: begin
                ar = (128'(da) * 128'(da) * 128'(PI_Q24)) >> (24 + FRAC_BITS);
                pr = (128'(2) * 128'(PI_Q24) * 128'(da)) >> 24;
            end
            default: begin
                cr = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
                if (cr < 0) cr = -cr;
                ar = 128'(cr) << (FRAC_BITS - 1);
                pr = 128'(edge_root(x1 - x2, y1 - y2)) + 128'(edge_root(x2 - x3, y2 - y3))
                   + 128'(edge_root(x3 - x1, y3 - y1));
            end
        endcase
        r.area = (ar > 128'(AREA_ALL)) ? AREA_ALL : ar[41:0];
        r.perim = (pr > 128'(PERIM_ALL)) ? PERIM_ALL : pr[26:0];
        return r;
    endfunction

    // offer one shape and wait for its transfer; valid stays up for a following shape
    task automatic send_shape(input logic [1:0] kind, input logic [143:0] data);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_q.insert(expected_q.size(), shape_measure(kind, data));
        kind_count[kind]++;
        items_sent++;
    endtask

    function automatic logic [143:0] pack_tri(input int x1, y1, x2, y2, x3, y3);
        return {16'(y3), 16'(x3), 16'(y2), 16'(x2), 16'(y1), 16'(x1), 48'(0)};
    endfunction

    function automatic logic [143:0] random_data();
        return {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
    endfunction

    // random dimension with a spread of magnitudes
    function automatic logic [23:0] random_dim();
        case ($urandom_range(3, 0))
            0: return 24'($urandom_range(255, 0));
            1: return 24'($urandom_range(65535, 0));
            2: return 24'hFFFFFF - 24'($urandom_range(15, 0));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic int random_coord();
        case ($urandom_range(3, 0))
            0: return $urandom_range(20, 0) - 10;
            1: return $urandom_range(1, 0) ? 32767 : -32768;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    // extremes of every kind plus degenerate triangles
    task automatic test_directed();
        send_shape(KIND_RECT, '0);
        send_shape(KIND_RECT, {96'(0), 24'hFFFFFF, 24'hFFFFFF});
        send_shape(KIND_RECT, {96'(0), 24'h000100, 24'h000380});
        send_shape(KIND_RECT, '1);
        send_shape(KIND_SQUARE, '0);
        send_shape(KIND_SQUARE, {120'(0), 24'hFFFFFF});
        send_shape(KIND_SQUARE, '1);
        send_shape(KIND_CIRCLE, '0);
        send_shape(KIND_CIRCLE, {120'(0), 24'h000100});
        send_shape(KIND_CIRCLE, {120'(0), 24'hFFFFFF});
        send_shape(KIND_CIRCLE, '1);
        send_shape(KIND_TRI, pack_tri(0, 0, 0, 0, 0, 0));
        send_shape(KIND_TRI, pack_tri(0, 0, 3, 0, 0, 4));
        send_shape(KIND_TRI, pack_tri(1, 1, 2, 2, 3, 3));
        send_shape(KIND_TRI, pack_tri(5, -7, 5, -7, 9, 2));
        send_shape(KIND_TRI, pack_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        send_shape(KIND_TRI, pack_tri(32767, 32767, -32768, 32767, 32767, -32768));
        send_shape(KIND_TRI, pack_tri(-32768, -32768, 32767, 32767, -32768, 32767));
        send_shape(KIND_TRI, '1);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [1:0]   kind;
        logic [143:0] data;
        repeat (count) begin
            kind = 2'($urandom_range(3, 0));
            data = random_data();
            if ($urandom_range(9, 0) != 0) begin
                if (kind == KIND_TRI)
                    data = pack_tri(random_coord(), random_coord(), random_coord(),
                                    random_coord(), random_coord(), random_coord())
                           | {96'(0), 48'($urandom())};
                else
                    data[47:0] = {random_dim(), random_dim()};
            end
            send_shape(kind, data);
        end
    endtask

    // receiver holds off while the sender keeps offering, then drains
    task automatic test_backpressure();
        hold_off_cycles = 200;
        test_random(40);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 33;
        recv_idle_pct = 50;
        test_random(640);
        wait_drained();
        send_idle_pct = 50;
        recv_idle_pct = 33;
        test_random(640);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(620);
        wait_drained();
        $display("%0d shapes sent (rect %0d, square %0d, circle %0d, triangle %0d),",
                 items_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("%0d results checked, with idle, stall and long hold-off phases", results_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver ready, with a counted long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        shape_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result area=%0d perim=%0d", $time,
                         m_axis_tdata[41:0], m_axis_tdata[68:42]);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[41:0] !== want.area) begin
                    errors++;
                    $display("%0t: area expected %0d actual %0d", $time, want.area,
                             m_axis_tdata[41:0]);
                end
                if (m_axis_tdata[68:42] !== want.perim) begin
                    errors++;
                    $display("%0t: perimeter expected %0d actual %0d", $time, want.perim,
                             m_axis_tdata[68:42]);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/sap_pkg.sv
design/sap_front.sv
design/sap_sqrt.sv
design/shape_area_perimeter.sv
dv/tb_shape_area_perimeter.sv
